// File: src/lcrw_pkg.sv
// ----------------------------------------------------------------------------
// lcrw_pkg
// Shared types, constants and control structs for the rectangular line clipper.
// ----------------------------------------------------------------------------
package lcrw_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * COORD_WIDTH;
    localparam int DIV_CNT_W   = $clog2(COORD_WIDTH);
    localparam int MOVE_CNT_W  = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int IN_TDATA_W  = ((4 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((4 * COORD_WIDTH + 1 + 7) / 8) * 8;

    localparam logic [MOVE_CNT_W-1:0] MAX_MOVES = MOVE_CNT_W'(8);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic [COORD_WIDTH-1:0]        mag_t;
    typedef logic [3:0]                    code_t;

    // outcode bit positions
    localparam int OC_LEFT  = 0;
    localparam int OC_RIGHT = 1;
    localparam int OC_BELOW = 2;
    localparam int OC_ABOVE = 3;

    localparam coord_t LEFT_RST   = COORD_WIDTH'(200);
    localparam coord_t RIGHT_RST  = COORD_WIDTH'(350);
    localparam coord_t BOTTOM_RST = COORD_WIDTH'(200);
    localparam coord_t TOP_RST    = COORD_WIDTH'(350);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LEFT,
        REG_RIGHT,
        REG_BOTTOM,
        REG_TOP
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic start_move;
        logic mul;
        logic div_step;
        logic update;
        logic load_out;
        logic visible;
    } lcrw_cmd_t;

    typedef struct packed {
        code_t code0;
        code_t code1;
    } lcrw_status_t;

    function automatic code_t outcode(coord_t x, coord_t y, coord_t l, coord_t r,
                                      coord_t b, coord_t t);
        code_t c;
        c           = '0;
        c[OC_LEFT]  = x < l;
        c[OC_RIGHT] = x > r;
        c[OC_BELOW] = y < b;
        c[OC_ABOVE] = y > t;
        return c;
    endfunction

endpackage

// File: src/lcrw_dp.sv
// ----------------------------------------------------------------------------
// lcrw_dp
// Window registers, endpoint registers, outcodes, multiplier and a radix-2
// restoring divider that computes one boundary intersection per move.
// ----------------------------------------------------------------------------
module lcrw_dp
    import lcrw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  coord_t                cfg_wdata,
    input  coord_t                in_start_x,
    input  coord_t                in_start_y,
    input  coord_t                in_end_x,
    input  coord_t                in_end_y,
    input  lcrw_cmd_t             cmd,
    output lcrw_status_t          status,
    output logic                  res_visible,
    output coord_t                res_start_x,
    output coord_t                res_start_y,
    output coord_t                res_end_x,
    output coord_t                res_end_y
);

    function automatic mag_t magnitude(diff_t v);
        diff_t n;
        n = -v;
        return v[DIFF_W-1] ? n[COORD_WIDTH-1:0] : v[COORD_WIDTH-1:0];
    endfunction

    coord_t win_left_reg, win_right_reg, win_bottom_reg, win_top_reg;
    coord_t x0_reg, y0_reg, x1_reg, y1_reg;
    mag_t   mag_a_reg, mag_b_reg, mag_c_reg;
    logic   neg_reg, first_reg, vert_reg;
    coord_t bound_reg, base_reg;
    mag_t   rem_reg, quo_reg;
    logic   vis_reg;
    coord_t out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;

    code_t  code0, code1, code_sel;
    logic   first, vert;
    coord_t px, py, ox, oy, bound;
    diff_t  da, db, dc;
    logic [PROD_W-1:0] prod;
    logic [COORD_WIDTH:0] trial, trial_sub;
    logic   ge;
    diff_t  q_ext, q_signed, new_sum;
    coord_t new_coord;

    assign code0 = outcode(x0_reg, y0_reg, win_left_reg, win_right_reg,
                           win_bottom_reg, win_top_reg);
    assign code1 = outcode(x1_reg, y1_reg, win_left_reg, win_right_reg,
                           win_bottom_reg, win_top_reg);
    assign status.code0 = code0;
    assign status.code1 = code1;

    // operand selection for the next boundary move
    always_comb
    begin
        first    = code0 != '0;
        code_sel = first ? code0 : code1;
        px       = first ? x0_reg : x1_reg;
        py       = first ? y0_reg : y1_reg;
        ox       = first ? x1_reg : x0_reg;
        oy       = first ? y1_reg : y0_reg;
        vert     = code_sel[OC_LEFT] | code_sel[OC_RIGHT];
        if (code_sel[OC_LEFT])
            bound = win_left_reg;
        else if (code_sel[OC_RIGHT])
            bound = win_right_reg;
        else if (code_sel[OC_BELOW])
            bound = win_bottom_reg;
        else
            bound = win_top_reg;
        if (vert)
        begin
            da = DIFF_W'(oy) - DIFF_W'(py);
            db = DIFF_W'(bound) - DIFF_W'(px);
            dc = DIFF_W'(ox) - DIFF_W'(px);
        end
        else
        begin
            da = DIFF_W'(ox) - DIFF_W'(px);
            db = DIFF_W'(bound) - DIFF_W'(py);
            dc = DIFF_W'(oy) - DIFF_W'(py);
        end
    end

    assign prod = PROD_W'(mag_a_reg) * PROD_W'(mag_b_reg);

    // one quotient bit per step
    assign trial     = {rem_reg, quo_reg[COORD_WIDTH-1]};
    assign ge        = trial >= {1'b0, mag_c_reg};
    assign trial_sub = trial - {1'b0, mag_c_reg};

    assign q_ext     = DIFF_W'({1'b0, quo_reg});
    assign q_signed  = neg_reg ? -q_ext : q_ext;
    assign new_sum   = DIFF_W'(base_reg) + q_signed;
    assign new_coord = new_sum[COORD_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= LEFT_RST;
            win_right_reg  <= RIGHT_RST;
            win_bottom_reg <= BOTTOM_RST;
            win_top_reg    <= TOP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_LEFT:   win_left_reg   <= cfg_wdata;
                REG_RIGHT:  win_right_reg  <= cfg_wdata;
                REG_BOTTOM: win_bottom_reg <= cfg_wdata;
                REG_TOP:    win_top_reg    <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x0_reg <= in_start_x;
            y0_reg <= in_start_y;
            x1_reg <= in_end_x;
            y1_reg <= in_end_y;
        end
        else if (cmd.update)
        begin
            if (first_reg)
            begin
                x0_reg <= vert_reg ? bound_reg : new_coord;
                y0_reg <= vert_reg ? new_coord : bound_reg;
            end
            else
            begin
                x1_reg <= vert_reg ? bound_reg : new_coord;
                y1_reg <= vert_reg ? new_coord : bound_reg;
            end
        end

        if (cmd.start_move)
        begin
            mag_a_reg <= magnitude(da);
            mag_b_reg <= magnitude(db);
            mag_c_reg <= magnitude(dc);
            neg_reg   <= da[DIFF_W-1] ^ db[DIFF_W-1] ^ dc[DIFF_W-1];
            first_reg <= first;
            vert_reg  <= vert;
            bound_reg <= bound;
            base_reg  <= vert ? py : px;
        end

        if (cmd.mul)
        begin
            rem_reg <= prod[PROD_W-1:COORD_WIDTH];
            quo_reg <= prod[COORD_WIDTH-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? trial_sub[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
            quo_reg <= {quo_reg[COORD_WIDTH-2:0], ge};
        end

        if (cmd.load_out)
        begin
            vis_reg    <= cmd.visible;
            out_sx_reg <= cmd.visible ? x0_reg : '0;
            out_sy_reg <= cmd.visible ? y0_reg : '0;
            out_ex_reg <= cmd.visible ? x1_reg : '0;
            out_ey_reg <= cmd.visible ? y1_reg : '0;
        end
    end

    assign res_visible = vis_reg;
    assign res_start_x = out_sx_reg;
    assign res_start_y = out_sy_reg;
    assign res_end_x   = out_ex_reg;
    assign res_end_y   = out_ey_reg;

endmodule

// File: src/lcrw_ctrl.sv
// ----------------------------------------------------------------------------
// lcrw_ctrl
// Sequencer: accept/reject decisions, move count, divider step count and
// the output word handshake.
// ----------------------------------------------------------------------------
module lcrw_ctrl
    import lcrw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  lcrw_status_t status,
    output lcrw_cmd_t    cmd
);

    state_t                state_reg, state_next;
    logic [MOVE_CNT_W-1:0] move_cnt_reg, move_cnt_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  visible_reg, visible_next;
    logic                  out_valid_reg, out_valid_next;

    logic trivial_accept, reject;
    logic out_free;

    assign trivial_accept = (status.code0 | status.code1) == '0;
    assign reject         = ((status.code0 & status.code1) != '0)
                            || (move_cnt_reg >= MAX_MOVES);
    assign out_free       = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next    = state_reg;
        move_cnt_next = move_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        visible_next  = visible_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    move_cnt_next = '0;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (trivial_accept)
                begin
                    visible_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (reject)
                begin
                    visible_next = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    move_cnt_next = move_cnt_reg + 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(COORD_WIDTH - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
                state_next = ST_EVAL;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        cmd.visible    = visible_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_EVAL:
                cmd.start_move = !trivial_accept && !reject;
            ST_MUL:
                cmd.mul = 1'b1;
            ST_DIV:
                cmd.div_step = 1'b1;
            ST_UPDATE:
                cmd.update = 1'b1;
            ST_DONE:
                cmd.load_out = out_free;
            default:
                ;
        endcase
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            move_cnt_reg  <= '0;
            div_cnt_reg   <= '0;
            visible_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            move_cnt_reg  <= move_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            visible_reg   <= visible_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/line_clip_rect_window.sv
// ----------------------------------------------------------------------------
// line_clip_rect_window
// Cohen-Sutherland clipper: clips one segment per input word to the window
// held in four configuration registers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready     start_x, start_y, end_x, end_y
//  m_*       out  m_tvalid / m_tready     visible, clipped start and end point
//  cfg_*     in   cfg_wr_en (no wait)     cfg_addr selects left/right/bottom/top
//
//  Flow: one segment at a time. Accept, evaluate, then per boundary move
//  operand setup, 16x16 multiply, one divider bit per cycle over
//  COORD_WIDTH bits and writeback, then back to evaluate; last the
//  output register. At most 8 moves per segment.
//  Reset: async active low; window comes up as left/bottom 200, right/top 350.
//  Stalls: the output register holds a finished word while the next segment
//  is taken and worked; a second finished word waits until m_tready.
// ----------------------------------------------------------------------------
module line_clip_rect_window
    import lcrw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [COORD_WIDTH-1:0] cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, low bit up: start_x, start_y, end_x, end_y
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, low bit up: visible, clipped_start_x, clipped_start_y,
    // clipped_end_x, clipped_end_y, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    lcrw_cmd_t    cmd;
    lcrw_status_t status;
    logic         res_visible;
    coord_t       res_start_x, res_start_y, res_end_x, res_end_y;

    lcrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lcrw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_start_x  (s_tdata[COORD_WIDTH-1:0]),
        .in_start_y  (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .in_end_x    (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .in_end_y    (s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
        .cmd         (cmd),
        .status      (status),
        .res_visible (res_visible),
        .res_start_x (res_start_x),
        .res_start_y (res_start_y),
        .res_end_x   (res_end_x),
        .res_end_y   (res_end_y)
    );

    // pack the output word; fill bits are zero
    always_comb
    begin
        m_tdata = '0;
        m_tdata[0] = res_visible;
        m_tdata[COORD_WIDTH:1]                 = res_start_x;
        m_tdata[2*COORD_WIDTH:COORD_WIDTH+1]   = res_start_y;
        m_tdata[3*COORD_WIDTH:2*COORD_WIDTH+1] = res_end_x;
        m_tdata[4*COORD_WIDTH:3*COORD_WIDTH+1] = res_end_y;
    end

`ifndef SYNTH
    // one segment in flight: no second word is taken right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a segment is in progress");

    // a visible result only leaves with both endpoints inside the window
    a_visible_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && cmd.visible |-> (status.code0 | status.code1) == '0)
        else $error("visible result with an endpoint outside the window");

    // a rejected segment carries zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("rejected segment with nonzero coordinates");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_clip_rect_window. Segments go in on the s_*
// stream, and a Cohen-Sutherland model inside the bench works out the
// visible flag and the clipped endpoints of each one, using the window it
// last wrote. Each word on m_* is checked field by field against the oldest
// prediction. Both streams idle and stall at random. The window is rewritten
// between phases, only once every expected word has come back.
// ----------------------------------------------------------------------------
module tb;
    import lcrw_pkg::*;

    // longest run of cycles with no word moving on either stream
    localparam int QUIET_LIMIT = 3000;
    // drain wait at the end: longer than the worst clip time
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic   visible;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } clip_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = REG_LEFT;
    logic [COORD_WIDTH-1:0] cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // s_tdata, low bit up: start_x, start_y, end_x, end_y
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // m_tdata, low bit up: visible, clipped_start_x, clipped_start_y,
    // clipped_end_x, clipped_end_y, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;

    // bench copy of the window registers
    coord_t win_left   = LEFT_RST;
    coord_t win_right  = RIGHT_RST;
    coord_t win_bottom = BOTTOM_RST;
    coord_t win_top    = TOP_RST;

    clip_result_t clip_expected[$];
    int           mismatches   = 0;
    int           quiet_cycles = 0;
    int           ready_hold   = 0;
    bit           gaps_on      = 1'b1;

    line_clip_rect_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // clipping model
    // ------------------------------------------------------------------

    function automatic code_t region_code(longint x, longint y);
        code_t c;
        c           = '0;
        c[OC_LEFT]  = x < longint'(win_left);
        c[OC_RIGHT] = x > longint'(win_right);
        c[OC_BELOW] = y < longint'(win_bottom);
        c[OC_ABOVE] = y > longint'(win_top);
        return c;
    endfunction

    // trunc(num * part / whole); the product fits easily in 64 bits and
    // signed division here truncates toward zero
    function automatic longint scaled_offset(longint num, longint part, longint whole);
        return (num * part) / whole;
    endfunction

    function automatic clip_result_t clip_segment(coord_t sx, coord_t sy,
                                                  coord_t ex, coord_t ey);
        longint       x0, y0, x1, y1, px, py, ox, oy, nx, ny;
        code_t        c0, c1, c;
        bit           first, done;
        int           moves;
        clip_result_t r;
        x0 = sx;
        y0 = sy;
        x1 = ex;
        y1 = ey;
        c0 = region_code(x0, y0);
        c1 = region_code(x1, y1);
        r  = '{default: '0};
        done  = 1'b0;
        moves = 0;
        while (!done)
        begin
            if ((c0 | c1) == '0)
            begin
                r.visible = 1'b1;
                done      = 1'b1;
            end
            else if ((c0 & c1) != '0 || moves >= int'(MAX_MOVES))
            begin
                // shared outside region, or loop bound hit: rejected
                done = 1'b1;
            end
            else
            begin
                moves++;
                first = (c0 != '0);
                c  = first ? c0 : c1;
                px = first ? x0 : x1;
                py = first ? y0 : y1;
                ox = first ? x1 : x0;
                oy = first ? y1 : y0;
                // lowest set bit picks the boundary: left, right, below, above
                if (c[OC_LEFT] || c[OC_RIGHT])
                begin
                    nx = c[OC_LEFT] ? longint'(win_left) : longint'(win_right);
                    ny = py + scaled_offset(oy - py, nx - px, ox - px);
                end
                else
                begin
                    ny = c[OC_BELOW] ? longint'(win_bottom) : longint'(win_top);
                    nx = px + scaled_offset(ox - px, ny - py, oy - py);
                end
                if (first)
                begin
                    x0 = nx;
                    y0 = ny;
                    c0 = region_code(x0, y0);
                end
                else
                begin
                    x1 = nx;
                    y1 = ny;
                    c1 = region_code(x1, y1);
                end
            end
        end
        if (r.visible)
        begin
            r.start_x = coord_t'(x0);
            r.start_y = coord_t'(y0);
            r.end_x   = coord_t'(x1);
            r.end_y   = coord_t'(y1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly back to back, often a few cycles, now and then a long pause
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // coordinate near an axis of the window, anywhere, or on an edge value
    function automatic coord_t pick_coord(longint lo, longint hi);
        longint span, v, t;
        int     mode;
        if (lo > hi)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        span = hi - lo + 16;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            v = lo - span + longint'($urandom_range(0, 3 * span));
        else if (mode < 8)
            v = longint'(coord_t'($urandom));
        else
        begin
            case ($urandom_range(0, 5))
                0:       v = lo;
                1:       v = hi;
                2:       v = lo - 1;
                3:       v = hi + 1;
                4:       v = -32768;
                default: v = 32767;
            endcase
        end
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return coord_t'(v);
    endfunction

    // one segment word; s_tvalid stays high when the next word follows
    // with no gap, so it is only lowered at the start of a gap
    task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({ey, ex, sy, sx});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        clip_expected.push_back(clip_segment(sx, sy, ex, ey));
    endtask

    // window writes only with the clipper idle: input quiet, nothing owed
    task automatic set_window(coord_t l, coord_t r, coord_t b, coord_t t);
        s_tvalid <= 1'b0;
        while (clip_expected.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_LEFT;
        cfg_wdata <= l;
        @(posedge clk);
        cfg_addr  <= REG_RIGHT;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_addr  <= REG_BOTTOM;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_addr  <= REG_TOP;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        win_left   = l;
        win_right  = r;
        win_bottom = b;
        win_top    = t;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // window left at its reset values (200..350 on both axes)
    task automatic test_reset_window();
        send_segment(250, 250, 300, 300);           // fully inside
        send_segment(0, 250, 100, 300);             // both left: reject
        send_segment(250, 400, 300, 900);           // both above: reject
        send_segment(100, 275, 400, 275);           // crosses left and right
        send_segment(275, -32768, 275, 32767);      // vertical, full span
        send_segment(150, 150, 400, 400);           // corner to corner
        send_segment(0, 340, 210, 500);             // misses the top left corner
        send_segment(-32768, -32768, 32767, 32767); // field extremes
        send_segment(32767, -32768, -32768, 32767);
        send_segment(200, 200, 350, 350);           // endpoints on the boundary
        send_segment(275, 275, 275, 275);           // point inside
        send_segment(0, 0, 0, 0);                   // point outside
        send_segment(199, 275, 351, 275);           // just outside both sides
        send_segment(100, 201, 400, 349);           // truncation on both ends
    endtask

    task automatic test_window_limits();
        set_window(-32768, 32767, -32768, 32767);   // whole plane
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(0, 0, -1, -1);
        set_window(0, 0, 0, 0);                     // single point
        send_segment(-5, -3, 5, 3);
        send_segment(-10, 1, 10, 1);
        set_window(32767, 32767, -32768, -32768);   // bottom right corner
        send_segment(-32768, -32768, 32767, -32768);
    endtask

    // left > right or bottom > top: endpoints bounce between the
    // boundaries until the move bound or a shared code ends it
    task automatic test_inverted_window();
        set_window(300, 100, 100, 300);
        send_segment(0, 200, 400, 200);
        send_segment(200, 0, 200, 400);
        set_window(300, 100, -32768, 32767);
        send_segment(0, 5, 400, 9);
        set_window(-100, 100, 50, -50);
        send_segment(0, -200, 0, 200);
    endtask

    task automatic test_random_windows();
        coord_t a, b, c, d, t;
        int     mode, half_x, half_y;
        for (int phase = 0; phase < 6; phase++)
        begin
            mode = (phase == 0) ? 3 : $urandom_range(0, 9);
            a = coord_t'($urandom);
            b = coord_t'($urandom);
            c = coord_t'($urandom);
            d = coord_t'($urandom);
            if (mode >= 3)
            begin
                // small window, the usual case
                half_x = $urandom_range(0, 500);
                half_y = $urandom_range(0, 500);
                a = coord_t'($urandom_range(0, 60000) - 30000);
                c = coord_t'($urandom_range(0, 60000) - 30000);
                b = a + coord_t'(half_x);
                a = a - coord_t'(half_x);
                d = c + coord_t'(half_y);
                c = c - coord_t'(half_y);
            end
            else if (mode == 0)
            begin
                a = -32768;
                b = 32767;
                c = -32768;
                d = 32767;
            end
            else
            begin
                // wide random; mode 1 keeps the order inverted
                if ((a > b) == (mode == 2))
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                if ((c > d) == (mode == 2))
                begin
                    t = c;
                    c = d;
                    d = t;
                end
            end
            set_window(a, b, c, d);
            // one phase runs with both streams flat out
            gaps_on = (phase != 2);
            for (int n = 0; n < 80; n++)
                send_segment(pick_coord(win_left, win_right), pick_coord(win_bottom, win_top),
                             pick_coord(win_left, win_right), pick_coord(win_bottom, win_top));
            gaps_on = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // sink side: random stalls, then check each word taken
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_output
        clip_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (clip_expected.size() == 0)
            begin
                $error("output word %h with nothing expected", m_tdata);
                mismatches++;
            end
            else
            begin
                want = clip_expected.pop_front();
                check_field("visible", want.visible, m_tdata[0]);
                check_field("clipped_start_x", want.start_x,
                            coord_t'(m_tdata[1 +: COORD_WIDTH]));
                check_field("clipped_start_y", want.start_y,
                            coord_t'(m_tdata[1 + COORD_WIDTH +: COORD_WIDTH]));
                check_field("clipped_end_x", want.end_x,
                            coord_t'(m_tdata[1 + 2 * COORD_WIDTH +: COORD_WIDTH]));
                check_field("clipped_end_y", want.end_y,
                            coord_t'(m_tdata[1 + 3 * COORD_WIDTH +: COORD_WIDTH]));
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles in which neither stream moves a word
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin : run
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_window_limits();
        test_inverted_window();
        test_random_windows();
        s_tvalid <= 1'b0;
        while (clip_expected.size() != 0)
            @(posedge clk);
        // catch any stray word after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
